// ===== rtl/itar_pkg.sv =====
`timescale 1ns / 1ps

package itar_pkg;

  // Widths of the item fields.
  localparam int VALUE_W = 32;
  localparam int CHAR_W  = 8;
  localparam int COUNT_W = 6;
  localparam int RADIX_W = 5;

  // Legal bases and the base after reset.
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

  // Digit store: at most one digit per magnitude bit.
  localparam int MAX_DIGITS = 32;
  localparam int DIGIT_W    = 4;
  localparam int ADDR_W     = $clog2(MAX_DIGITS);

  // The divider retires this many quotient bits per cycle.
  localparam int BITS_PER_CYCLE = 4;
  localparam int DIV_CYCLES     = VALUE_W / BITS_PER_CYCLE;
  localparam int STEP_W         = $clog2(DIV_CYCLES);

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_DIGIT,
    ST_FETCH,
    ST_TERM
  } itar_state_t;

  // Lower-case glyph for one digit value.
  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 4'd10) begin
      glyph = CHAR_ZERO + d_ext;
    end else begin
      glyph = CHAR_LOWER + d_ext - 8'd10;
    end
  endfunction

endpackage

// ===== rtl/itar_value_if.sv =====
`timescale 1ns / 1ps

interface itar_value_if import itar_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// ===== rtl/itar_text_if.sv =====
`timescale 1ns / 1ps

interface itar_text_if import itar_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  character;
  logic [COUNT_W-1:0] digit_count;
  logic               bad_radix;
  logic               last;

  modport source (output valid, output character, output digit_count,
                  output bad_radix, output last, input ready);
  modport sink (input valid, input character, input digit_count,
                input bad_radix, input last, output ready);
endinterface

// ===== rtl/int_to_ascii_radix.sv =====
`timescale 1ns / 1ps

// Channel     Direction  Contents
// value_ch    in         value: signed 32-bit integer, one item per conversion
// text_ch     out        character, digit_count, bad_radix, last per character
// cfg_wr_*    in         radix register (5 bits), write only
//
// One shared divider of four compare-subtract steps divides the magnitude
// by the radix, retiring four quotient bits a cycle. Digits are kept in a
// 32-entry store and read back most significant first, with one output
// register towards the sink. Reset is synchronous and sets the radix to 10.
// A stalled sink holds the sequencer at the next character; a bad radix
// gives one error item.

module int_to_ascii_radix
  import itar_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [RADIX_W-1:0] cfg_wr_data,
  itar_value_if.sink         value_ch,
  itar_text_if.source        text_ch
);

  itar_state_t state, state_next;

  logic [RADIX_W-1:0] radix;
  logic [VALUE_W-1:0] num;
  logic [RADIX_W-1:0] rem;
  logic [STEP_W-1:0]  step;
  logic [COUNT_W-1:0] nd;
  logic [ADDR_W-1:0]  idx;
  logic               neg;
  logic [COUNT_W-1:0] count;

  logic [DIGIT_W-1:0] mem [MAX_DIGITS];
  logic [DIGIT_W-1:0] rdata;

  logic               o_valid;
  logic [CHAR_W-1:0]  o_char;
  logic [COUNT_W-1:0] o_count;
  logic               o_bad;
  logic               o_last;

  logic               accept, slot_free, radix_bad;
  logic               digit_done, last_digit;
  logic [VALUE_W-1:0] mag;
  logic [VALUE_W-1:0] div_num;
  logic [RADIX_W-1:0] div_rem;

  logic               out_load, out_bad, out_last;
  logic [CHAR_W-1:0]  out_char;
  logic [COUNT_W-1:0] out_cnt;

  // Radix register.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix <= cfg_wr_data;
    end
  end

  // Handshake and input conditioning.
  assign slot_free      = !o_valid || text_ch.ready;
  assign value_ch.ready = (state == ST_IDLE) && slot_free;
  assign accept         = value_ch.valid && value_ch.ready;
  assign radix_bad      = (radix < RADIX_MIN) || (radix > RADIX_MAX);
  assign mag            = value_ch.value[VALUE_W-1] ? (32'd0 - value_ch.value)
                                                    : value_ch.value;

  // Shared divider: four restoring compare-subtract steps a cycle.
  always_comb begin
    div_num = num;
    div_rem = rem;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      div_rem = {div_rem[RADIX_W-2:0], div_num[VALUE_W-1]};
      div_num = {div_num[VALUE_W-2:0], 1'b0};
      if (div_rem >= radix) begin
        div_rem    = div_rem - radix;
        div_num[0] = 1'b1;
      end
    end
  end

  assign digit_done = (state == ST_DIV) && (step == STEP_W'(DIV_CYCLES - 1));
  assign last_digit = digit_done &&
                      ((div_num == '0) || (nd == COUNT_W'(MAX_DIGITS - 1)));

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and output loads.
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    out_char   = CHAR_NUL;
    out_cnt    = count;
    out_bad    = 1'b0;
    out_last   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (radix_bad) begin
            out_load = 1'b1;
            out_cnt  = '0;
            out_bad  = 1'b1;
            out_last = 1'b1;
          end else begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (last_digit) begin
          state_next = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (!neg) begin
          state_next = ST_DIGIT;
        end else if (slot_free) begin
          out_load   = 1'b1;
          out_char   = CHAR_MINUS;
          state_next = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_char   = glyph(rdata);
          state_next = (idx == '0) ? ST_TERM : ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_DIGIT;
      end
      ST_TERM: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_char   = CHAR_NUL;
          out_last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Divider step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (accept) begin
      step <= '0;
    end else if (state == ST_DIV) begin
      step <= step + 1'b1;
    end
  end

  // Conversion datapath.
  always_ff @(posedge clk) begin
    if (accept && !radix_bad) begin
      num <= mag;
      rem <= '0;
      nd  <= '0;
      neg <= value_ch.value[VALUE_W-1];
    end else if (state == ST_DIV) begin
      num <= div_num;
      if (digit_done) begin
        rem <= '0;
        nd  <= nd + 1'b1;
        if (last_digit) begin
          idx   <= nd[ADDR_W-1:0];
          count <= nd + 1'b1 + {{(COUNT_W-1){1'b0}}, neg};
        end
      end else begin
        rem <= div_rem;
      end
    end else if ((state == ST_DIGIT) && slot_free && (idx != '0)) begin
      idx <= idx - 1'b1;
    end
  end

  // Digit store, least significant digit at address zero.
  always_ff @(posedge clk) begin
    if (digit_done) begin
      mem[nd[ADDR_W-1:0]] <= div_rem[DIGIT_W-1:0];
    end
    rdata <= mem[idx];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_load) begin
      o_valid <= 1'b1;
    end else if (text_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_char  <= out_char;
      o_count <= out_cnt;
      o_bad   <= out_bad;
      o_last  <= out_last;
    end
  end

  assign text_ch.valid       = o_valid;
  assign text_ch.character   = o_char;
  assign text_ch.digit_count = o_count;
  assign text_ch.bad_radix   = o_bad;
  assign text_ch.last        = o_last;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench
  import itar_pkg::*;
();

  // Cycles without any accepted item before the run is declared hung. The slowest
  // correct conversion (base 2, most negative value) gives 34 characters, with the
  // longest sink stall and the deliberate long hold-off on top of it.
  localparam int HANG_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_CYCLES  = 400;
  localparam int LONG_HOLD     = 600;
  localparam int MAX_WAIT      = 18;

  // Idle patterns for either side of the block.
  typedef enum int {
    IDLE_NONE,
    IDLE_UNIFORM,
    IDLE_SPARSE
  } idle_mode_t;

  // One character item as seen on the text channel.
  typedef struct packed {
    logic [CHAR_W-1:0]  character;
    logic [COUNT_W-1:0] digit_count;
    logic               bad_radix;
    logic               last;
  } text_item_t;

  // Predicts the text of each converted value and checks the characters that come out.
  class itoa_text_model;
    logic [RADIX_W-1:0] radix;
    text_item_t         pending_chars[$];
    int                 mismatches;

    function new();
      radix = RADIX_RESET;
      mismatches = 0;
    endfunction

    function void add_char(logic [CHAR_W-1:0] ch, logic [COUNT_W-1:0] cnt,
                           logic bad, logic fin);
      text_item_t t;
      t.character   = ch;
      t.digit_count = cnt;
      t.bad_radix   = bad;
      t.last        = fin;
      pending_chars.push_back(t);
    endfunction

    // Spell the value in the current base; the magnitude of the most negative
    // value wraps to 2^31 as an unsigned number.
    function void note_value(logic signed [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] mag;
      logic [VALUE_W-1:0] base;
      logic [DIGIT_W-1:0] digs [0:MAX_DIGITS-1];
      logic [DIGIT_W-1:0] d;
      logic               neg;
      logic [COUNT_W-1:0] cnt;
      int                 nd;
      if (radix < RADIX_MIN || radix > RADIX_MAX) begin
        add_char(CHAR_NUL, '0, 1'b1, 1'b1);
        return;
      end
      base = {{(VALUE_W-RADIX_W){1'b0}}, radix};
      neg = v[VALUE_W-1];
      mag = neg ? (32'd0 - v) : v;
      nd = 0;
      do begin
        digs[nd] = DIGIT_W'(mag % base);
        nd++;
        mag = mag / base;
      end while (mag != 0 && nd < MAX_DIGITS);
      cnt = COUNT_W'(nd + (neg ? 1 : 0));
      if (neg) begin
        add_char(CHAR_MINUS, cnt, 1'b0, 1'b0);
      end
      for (int i = nd - 1; i >= 0; i--) begin
        d = digs[i];
        add_char((d > 4'd9) ? CHAR_LOWER + CHAR_W'(d - 4'd10) : CHAR_ZERO + CHAR_W'(d),
                 cnt, 1'b0, 1'b0);
      end
      add_char(CHAR_NUL, cnt, 1'b0, 1'b1);
    endfunction

    // Compare one received character with the oldest one predicted.
    function void check_char(text_item_t got);
      text_item_t want;
      if (pending_chars.size() == 0) begin
        $error("character item with none predicted: character=%0h count=%0d bad=%0b last=%0b",
               got.character, got.digit_count, got.bad_radix, got.last);
        mismatches++;
        return;
      end
      want = pending_chars.pop_front();
      if (got.character !== want.character) begin
        $error("character: expected %0h, actual %0h", want.character, got.character);
        mismatches++;
      end
      if (got.digit_count !== want.digit_count) begin
        $error("digit_count: expected %0d, actual %0d", want.digit_count, got.digit_count);
        mismatches++;
      end
      if (got.bad_radix !== want.bad_radix) begin
        $error("bad_radix: expected %0b, actual %0b", want.bad_radix, got.bad_radix);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [RADIX_W-1:0] cfg_wr_data;
  int                 rx_hold;
  idle_mode_t         tx_mode;
  int                 quiet_cycles;

  itar_value_if value_ch ();
  itar_text_if  text_ch ();

  itoa_text_model text_model = new();

  int_to_ascii_radix DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .value_ch    (value_ch),
    .text_ch     (text_ch)
  );

  // Clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Number of idle cycles before the next item, by pattern.
  function automatic int draw_wait(idle_mode_t mode);
    case (mode)
      IDLE_NONE:    return 0;
      IDLE_UNIFORM: return $urandom_range(0, MAX_WAIT);
      default:      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
    endcase
  endfunction

  // A mix of full-range, small, near-extreme and mid-sized values.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4:          return $urandom_range(0, 40);
      5:          return 32'd0 - $urandom_range(0, 40);
      6:          return 32'h7fff_ffff - $urandom_range(0, 15);
      7:          return 32'h8000_0000 + $urandom_range(0, 15);
      8:          return $urandom() >> $urandom_range(1, 31);
      default:    return 32'd0 - ($urandom() >> $urandom_range(1, 31));
    endcase
  endfunction

  // Mostly legal bases, now and then an illegal one.
  function automatic logic [RADIX_W-1:0] pick_radix();
    if ($urandom_range(0, 9) != 0) begin
      return RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
    end
    return $urandom_range(0, 1) ? RADIX_W'($urandom_range(17, 31))
                                : RADIX_W'($urandom_range(0, 1));
  endfunction

  // Offer one value and wait until it is taken. Valid stays high across
  // back-to-back items.
  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    gap = draw_wait(tx_mode);
    if (gap > 0) begin
      value_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    value_ch.valid <= 1'b1;
    value_ch.value <= v;
    do @(posedge clk); while (value_ch.ready !== 1'b1);
    text_model.note_value(v);
  endtask

  // Change the base once every predicted character has arrived.
  task automatic write_radix(input logic [RADIX_W-1:0] r);
    value_ch.valid <= 1'b0;
    while (text_model.pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    text_model.radix = r;
  endtask

  // Text sink: random stalls in changing patterns, plus the long hold-off on request.
  initial begin : text_sink
    int         stall;
    int         run_left;
    idle_mode_t mode;
    text_item_t got;
    run_left = 0;
    mode = IDLE_NONE;
    text_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (run_left == 0) begin
        mode = idle_mode_t'($urandom_range(0, 2));
        run_left = $urandom_range(10, 40);
      end
      run_left--;
      if (rx_hold > 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end else begin
        stall = draw_wait(mode);
      end
      if (stall > 0) begin
        text_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      text_ch.ready <= 1'b1;
      do @(posedge clk); while (text_ch.valid !== 1'b1);
      got.character   = text_ch.character;
      got.digit_count = text_ch.digit_count;
      got.bad_radix   = text_ch.bad_radix;
      got.last        = text_ch.last;
      text_model.check_char(got);
    end
  end

  // Hang detection: count cycles in which neither channel moves an item.
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((value_ch.valid === 1'b1 && value_ch.ready === 1'b1) ||
        (text_ch.valid === 1'b1 && text_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("int_to_ascii_radix test failed");
      $finish;
    end
  end

  // Main sequence: reset, directed values, random phases, long hold-off, drain.
  initial begin : stimulus
    logic [RADIX_W-1:0] phase_radix [0:3];
    rx_hold = 0;
    tx_mode = IDLE_UNIFORM;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    value_ch.valid <= 1'b0;
    value_ch.value <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Decimal after reset: zero, small values, both extremes.
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hffff_ffff);
    send_value(32'd10);
    send_value(32'd0 - 32'd100);
    send_value(32'h7fff_ffff);
    send_value(32'h8000_0000);
    send_value(32'd1_000_000_000);

    // Base 2: the longest strings, including the most negative value.
    write_radix(RADIX_MIN);
    send_value(32'h8000_0000);
    send_value(32'd0);
    send_value(32'h7fff_ffff);
    send_value(32'hffff_ffff);
    send_value(32'h5555_5555);

    // Base 16: every letter digit.
    write_radix(RADIX_MAX);
    send_value(32'h00ab_cdef);
    send_value(32'hdead_beef);
    send_value(32'h8000_0000);
    send_value(32'h7fff_ffff);
    send_value(32'd0);

    // Illegal bases give one error item per value.
    write_radix(5'd0);
    send_value(32'd5);
    send_value(32'd0);
    write_radix(5'd31);
    send_value(32'hffff_fff9);

    // Random phases; the first four pin bases 1, 17, 3 and 9, three of them next to the legal limits.
    phase_radix[0] = 5'd1;
    phase_radix[1] = 5'd17;
    phase_radix[2] = 5'd3;
    phase_radix[3] = 5'd9;
    for (int ph = 0; ph < 10; ph++) begin
      write_radix((ph < 4) ? phase_radix[ph] : pick_radix());
      tx_mode = idle_mode_t'($urandom_range(0, 2));
      for (int n = 0; n < 25; n++) begin
        send_value(pick_value());
      end
    end

    // Long sink hold-off while values keep coming back to back.
    write_radix(RADIX_MIN);
    tx_mode = IDLE_NONE;
    rx_hold = LONG_HOLD;
    for (int n = 0; n < 6; n++) begin
      send_value((n % 2 == 0) ? 32'h8000_0000 : pick_value());
    end

    value_ch.valid <= 1'b0;
    while (text_model.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (text_model.mismatches == 0) begin
      $display("int_to_ascii_radix test passed");
    end else begin
      $display("int_to_ascii_radix test failed");
    end
    $finish;
  end

endmodule
